// ===== hdl/aes_pkg.sv =====
// AES package: state enum, control/status structs, S-box tables and round helpers.
// No dependencies; used by every module in hdl/.
package aes_pkg;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StInit,
    StRound,
    StOut
  } aes_state_e;

  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  localparam logic [2:0] RegKey0   = 3'd0;
  localparam logic [2:0] RegKey1   = 3'd1;
  localparam logic [2:0] RegKey2   = 3'd2;
  localparam logic [2:0] RegKey3   = 3'd3;
  localparam logic [2:0] RegKeyLen = 3'd4;
  localparam logic [2:0] RegIvHigh = 3'd5;
  localparam logic [2:0] RegIvLow  = 3'd6;
  localparam logic [2:0] RegMode   = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic       exp_start;  // latch key length, restart schedule index
    logic       exp_step;   // compute one schedule word
    logic       load;       // capture input block, do initial key add
    logic       round;      // one cipher round
    logic       last;       // this round is the final one
    logic       finish;     // output XOR and chain update
    logic [3:0] rnd;        // round key index for this cycle
  } aes_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic       exp_done;
    logic [3:0] rounds;
  } aes_stat_t;

  localparam logic [7:0] FwdBox [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] InvBox [256] = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  localparam logic [7:0] RoundConst [11] = '{
    8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
  endfunction

  // forward column mix
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, all;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    mix_col = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
               a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

  // inverse column mix: multiply by 4 correction, then forward mix
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage

// ===== hdl/aes_ctrl.sv =====
// AES controller: sequences key expansion, rounds and result handoff.
// Depends on aes_pkg.
module aes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              key_dirty_i,
  input  aes_pkg::aes_stat_t stat_i,
  output aes_pkg::aes_ctrl_t ctrl_o
);
  import aes_pkg::*;

  aes_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       dec_q, dec_d;
  logic       sched_ok_q, sched_ok_d;

  // next state
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    dec_d      = dec_q;
    sched_ok_d = sched_ok_q & ~key_dirty_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          dec_d = in_op_i;
          if (!sched_ok_d) state_d = StExpand;
          else state_d = StInit;
        end
      end
      StExpand: begin
        if (stat_i.exp_done) begin
          sched_ok_d = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        state_d = StRound;
        cnt_d   = 4'd1;
      end
      StRound: begin
        if (cnt_q == stat_i.rounds) state_d = StOut;
        else cnt_d = cnt_q + 4'd1;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o           = '0;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    ctrl_o.exp_start = (state_q == StIdle) && in_valid_i && !(sched_ok_q && !key_dirty_i);
    case (state_q)
      StIdle:   in_ready_o = 1'b0;
      StExpand: ctrl_o.exp_step = 1'b1;
      StInit: begin
        ctrl_o.load = 1'b1;
        in_ready_o  = 1'b1;
        ctrl_o.rnd  = in_op_i ? stat_i.rounds : 4'd0;
      end
      StRound: begin
        ctrl_o.round = 1'b1;
        ctrl_o.last  = (cnt_q == stat_i.rounds);
        ctrl_o.rnd   = dec_q ? stat_i.rounds - cnt_q : cnt_q;
        ctrl_o.finish = ctrl_o.last;
      end
      StOut: out_valid_o = 1'b1;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      dec_q      <= 1'b0;
      sched_ok_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      dec_q      <= dec_d;
      sched_ok_q <= sched_ok_d;
    end
  end

endmodule

// ===== hdl/aes_dp.sv =====
// AES datapath: key schedule memory, one shared round unit, CBC chain.
// Depends on aes_pkg; driven by aes_ctrl commands.
module aes_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aes_pkg::aes_ctrl_t ctrl_i,
  output aes_pkg::aes_stat_t stat_o,
  input  logic [255:0]       key_i,
  input  logic [1:0]         key_len_i,
  input  logic [127:0]       iv_i,
  input  logic               cbc_i,
  input  logic               op_i,
  input  logic               start_chain_i,
  input  logic [127:0]       block_i,
  output logic [127:0]       result_o
);
  import aes_pkg::*;

  // round keys: 15 rows of 128 bits, written one word per expansion step
  logic [127:0] rk_mem [15];
  logic [31:0]  win_q [8];       // last nk schedule words
  logic [5:0]   widx_q;
  logic [3:0]   kdiv_q;          // widx / nk
  logic [2:0]   kmod_q;          // widx % nk
  logic [3:0]   nk_q, rounds_q;
  logic [127:0] rk_rd;
  logic [127:0] st_q, chain_q;
  logic [127:0] in_q;
  logic         dec_q;
  logic [5:0]   total;

  assign total  = {rounds_q, 2'b00} + 6'd4;
  assign stat_o.exp_done = (widx_q == total);
  assign stat_o.rounds   = rounds_q;

  // schedule step
  logic [31:0] t_w, new_w;
  always_comb begin
    t_w = win_q[nk_q[2:0] - 3'd1];
    if (kmod_q == 3'd0)
      t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {RoundConst[kdiv_q], 24'h0};
    else if (nk_q == 4'd8 && kmod_q == 3'd4)
      t_w = sub_word(t_w);
    new_w = win_q[0] ^ t_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q   <= '0;
      kdiv_q   <= '0;
      kmod_q   <= '0;
      nk_q     <= 4'd4;
      rounds_q <= 4'd10;
    end else if (ctrl_i.exp_start) begin
      nk_q     <= (key_len_i == KeyLen128) ? 4'd4 : (key_len_i == KeyLen192) ? 4'd6 : 4'd8;
      rounds_q <= (key_len_i == KeyLen128) ? 4'd10 : (key_len_i == KeyLen192) ? 4'd12 : 4'd14;
      widx_q   <= '0;
      kdiv_q   <= '0;
      kmod_q   <= '0;
    end else if (ctrl_i.exp_step && !stat_o.exp_done) begin
      widx_q <= widx_q + 6'd1;
      if (kmod_q == nk_q[2:0] - 3'd1 || (nk_q == 4'd8 && kmod_q == 3'd7)) begin
        kmod_q <= '0;
        kdiv_q <= kdiv_q + 4'd1;
      end else begin
        kmod_q <= kmod_q + 3'd1;
      end
    end
  end

  // window shift and memory write; first nk words come from the key
  logic [31:0] wr_w;
  assign wr_w = (kdiv_q == 4'd0) ? key_i[255 - 32*kmod_q -: 32] : new_w;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exp_step && !stat_o.exp_done) begin
      rk_mem[widx_q[5:2]][127 - 32*widx_q[1:0] -: 32] <= wr_w;
      // shift out oldest word within the nk-long window; newest lands at nk-1
      for (int i = 0; i < 7; i++) begin
        if (i == int'(nk_q) - 1) win_q[i] <= wr_w;
        else win_q[i] <= win_q[i+1];
      end
      win_q[7] <= wr_w;
    end
  end

  // round key read: the addressed round's row
  always_comb begin
    rk_rd = rk_mem[ctrl_i.rnd];
  end

  // one round, forward or inverse
  logic [127:0] sb, mx, rnd_out, pre;
  logic [127:0] chain_use;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        if (!dec_q)
          sb[127 - 8*(4*c+k) -: 8] = FwdBox[st_q[127 - 8*(4*((c+k)%4)+k) -: 8]];
        else
          sb[127 - 8*(4*((c+k)%4)+k) -: 8] = InvBox[st_q[127 - 8*(4*c+k) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (!dec_q) mx[127 - 32*c -: 32] = mix_col(sb[127 - 32*c -: 32]);
      else mx[127 - 32*c -: 32] = inv_mix_col(sb[127 - 32*c -: 32] ^ rk_rd[127 - 32*c -: 32]);
    end
    if (!dec_q) rnd_out = (ctrl_i.last ? sb : mx) ^ rk_rd;
    else rnd_out = ctrl_i.last ? (sb ^ rk_rd) : mx;
    chain_use = (cbc_i && start_chain_i) ? iv_i : chain_q;
    pre = (cbc_i && !op_i) ? (block_i ^ chain_use) : block_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chain_q <= '0;
    else if (ctrl_i.load) chain_q <= chain_use;
    else if (ctrl_i.finish && cbc_i) chain_q <= dec_q ? in_q : rnd_out;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      st_q  <= pre ^ rk_rd;
      in_q  <= block_i;
      dec_q <= op_i;
    end else if (ctrl_i.round) begin
      st_q <= rnd_out;
    end
    if (ctrl_i.finish)
      result_o <= (dec_q && cbc_i) ? (rnd_out ^ chain_q) : rnd_out;
  end

endmodule

// ===== hdl/aes_block_cipher_ecb_cbc_unit.sv =====
// AES-128/192/256 ECB/CBC block cipher, top level: APB registers, controller, datapath.
// Key expansion runs on the first block after reset or any key write; then one round per
// cycle through one shared round unit. One block at a time: no new block is taken until
// the result has been accepted.
// Reset (async, active low) clears registers and chain and marks the schedule stale.
module aes_block_cipher_ecb_cbc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic        start_chain_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  import aes_pkg::*;

  logic [63:0] key_q [4];
  logic [1:0]  key_len_q;
  logic [63:0] iv_hi_q, iv_lo_q;
  logic        mode_q;
  logic        wr_en, key_dirty;
  logic [2:0]  reg_idx;
  logic [127:0] result;
  aes_ctrl_t   ctrl;
  aes_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign key_dirty = wr_en && (reg_idx inside {RegKey0, RegKey1, RegKey2, RegKey3, RegKeyLen});

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      key_len_q <= '0;
      iv_hi_q   <= '0;
      iv_lo_q   <= '0;
      mode_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegKey0:   key_q[0]  <= pwdata;
        RegKey1:   key_q[1]  <= pwdata;
        RegKey2:   key_q[2]  <= pwdata;
        RegKey3:   key_q[3]  <= pwdata;
        RegKeyLen: key_len_q <= pwdata[1:0];
        RegIvHigh: iv_hi_q   <= pwdata;
        RegIvLow:  iv_lo_q   <= pwdata;
        RegMode:   mode_q    <= pwdata[0];
        default:   mode_q    <= mode_q;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      RegKey0:   prdata = key_q[0];
      RegKey1:   prdata = key_q[1];
      RegKey2:   prdata = key_q[2];
      RegKey3:   prdata = key_q[3];
      RegKeyLen: prdata = {62'h0, key_len_q};
      RegIvHigh: prdata = iv_hi_q;
      RegIvLow:  prdata = iv_lo_q;
      RegMode:   prdata = {63'h0, mode_q};
      default:   prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_op_i(op_i),
    .out_valid_o, .out_ready_i,
    .key_dirty_i(key_dirty),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  aes_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl), .stat_o(stat),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_len_i(key_len_q),
    .iv_i({iv_hi_q, iv_lo_q}),
    .cbc_i(mode_q),
    .op_i, .start_chain_i,
    .block_i({block_high_i, block_low_i}),
    .result_o(result)
  );

  assign result_high_o = result[127:64];
  assign result_low_o  = result[63:0];

  // result is stable while waiting
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result))
    else $error("result changed while stalled");
  // no input taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted with result pending");
  // acceptance is followed by round work, not an immediate result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early");

endmodule

// ===== verif/aes_tb_pkg.sv =====
// Shared AES testbench codes: operation, chaining mode and key length values.
// Depends on nothing; used by the checker and the testbench top.
package aes_tb_pkg;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam logic ModeEcb = 1'b0;
  localparam logic ModeCbc = 1'b1;

  // key length codes beyond the ones the RTL package names
  localparam logic [1:0] KeyLen256   = 2'd2;
  localparam logic [1:0] KeyLenSpare = 2'd3;

endpackage

// ===== verif/aes_cipher_checker.sv =====
// Watches the register port and both block channels of the AES unit, predicts every
// result block from its own AES model and compares. Depends on aes_pkg and aes_tb_pkg.
module aes_cipher_checker
  import aes_pkg::*;
  import aes_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic        start_chain_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] result_high_i,
  input  logic [63:0] result_low_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the register file and the cipher state
  logic [63:0]  key_w [4];
  logic [1:0]   key_len;
  logic [63:0]  iv_hi, iv_lo;
  logic         chain_on;
  logic         sched_ok;
  logic [127:0] chain;
  logic [31:0]  sched [60];
  int           n_rounds;
  logic [127:0] expected_blocks [$];

  assign pending_o = expected_blocks.size();

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc ^= x;
      x = dbl(x);
    end
    return acc;
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
  endfunction

  // rebuild the round key words from the shadow key registers
  task automatic build_schedule();
    int nk;
    logic [31:0] t;
    nk = (key_len == KeyLen128) ? 4 : (key_len == KeyLen192) ? 6 : 8;
    n_rounds = nk + 6;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
    for (int i = nk; i < 4 * (n_rounds + 1); i++) begin
      t = sched[i - 1];
      if (i % nk == 0)
        t = subst_word({t[23:0], t[31:24]}) ^ {RoundConst[(i / nk) % 11], 24'h0};
      else if (nk > 6 && i % nk == 4)
        t = subst_word(t);
      sched[i] = sched[i - nk] ^ t;
    end
    sched_ok = 1'b1;
  endtask

  function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
    return s ^ {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  endfunction

  function automatic logic [127:0] aes_encrypt_block(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    s = add_rk(s, 0);
    for (int r = 1; r <= n_rounds; r++) begin
      // byte substitution with row shift
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          t[127 - 8 * (4 * c + k) -: 8] = FwdBox[s[127 - 8 * (4 * ((c + k) % 4) + k) -: 8]];
      if (r != n_rounds) begin
        for (int c = 0; c < 4; c++) begin
          {a0, a1, a2, a3} = t[127 - 32 * c -: 32];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[127 - 32 * c -: 32] = {a0 ^ all ^ dbl(a0 ^ a1), a1 ^ all ^ dbl(a1 ^ a2),
                                   a2 ^ all ^ dbl(a2 ^ a3), a3 ^ all ^ dbl(a3 ^ a0)};
        end
      end
      s = add_rk(t, r);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_decrypt_block(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a, b, c2, d;
    s = add_rk(s, n_rounds);
    for (int r = n_rounds - 1; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          t[127 - 8 * (4 * ((c + k) % 4) + k) -: 8] = InvBox[s[127 - 8 * (4 * c + k) -: 8]];
      s = add_rk(t, r);
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          {a, b, c2, d} = s[127 - 32 * c -: 32];
          s[127 - 32 * c -: 32] = {
            gf_mul(a, 8'h0e) ^ gf_mul(b, 8'h0b) ^ gf_mul(c2, 8'h0d) ^ gf_mul(d, 8'h09),
            gf_mul(a, 8'h09) ^ gf_mul(b, 8'h0e) ^ gf_mul(c2, 8'h0b) ^ gf_mul(d, 8'h0d),
            gf_mul(a, 8'h0d) ^ gf_mul(b, 8'h09) ^ gf_mul(c2, 8'h0e) ^ gf_mul(d, 8'h0b),
            gf_mul(a, 8'h0b) ^ gf_mul(b, 8'h0d) ^ gf_mul(c2, 8'h09) ^ gf_mul(d, 8'h0e)};
        end
      end
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] blk, res, got, exp_blk;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      key_len  = KeyLen128;
      iv_hi    = '0;
      iv_lo    = '0;
      chain_on = ModeEcb;
      sched_ok = 1'b0;
      chain    = '0;
      n_rounds = 10;
      fail_count_o = 0;
      expected_blocks.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegKey0, RegKey1, RegKey2, RegKey3: begin
            key_w[paddr[4:3]] = pwdata;
            sched_ok = 1'b0;
          end
          RegKeyLen: begin
            key_len  = pwdata[1:0];
            sched_ok = 1'b0;
          end
          RegIvHigh: iv_hi = pwdata;
          RegIvLow:  iv_lo = pwdata;
          RegMode:   chain_on = pwdata[0];
          default: ;
        endcase
      end
      // accepted input block: predict its result
      if (in_valid_i && in_ready_i) begin
        if (!sched_ok) build_schedule();
        if (chain_on == ModeCbc && start_chain_i) chain = {iv_hi, iv_lo};
        blk = {block_high_i, block_low_i};
        if (op_i == OpEncrypt) begin
          res = aes_encrypt_block(chain_on == ModeCbc ? blk ^ chain : blk);
          if (chain_on == ModeCbc) chain = res;
        end else begin
          res = aes_decrypt_block(blk);
          if (chain_on == ModeCbc) begin
            res   = res ^ chain;
            chain = blk;
          end
        end
        expected_blocks.push_back(res);
      end
      // accepted result block: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = {result_high_i, result_low_i};
        if (expected_blocks.size() == 0) begin
          $error("unexpected result transaction %h", got);
          fail_count_o++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (got[127:64] !== exp_blk[127:64]) begin
            $error("result_high expected %h actual %h", exp_blk[127:64], got[127:64]);
            fail_count_o++;
          end
          if (got[63:0] !== exp_blk[63:0]) begin
            $error("result_low expected %h actual %h", exp_blk[63:0], got[63:0]);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/aes_block_cipher_ecb_cbc_unit_tb.sv =====
// Testbench top for the AES ECB/CBC unit: clock, reset, register writes and block traffic.
// Depends on aes_pkg, aes_tb_pkg, aes_cipher_checker and the unit itself.
module aes_block_cipher_ecb_cbc_unit_tb;
  import aes_pkg::*;
  import aes_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o, op_i, start_chain_i;
  logic [63:0] block_high_i, block_low_i;
  logic        out_valid_o, out_ready_i;
  logic [63:0] result_high_o, result_low_o;
  int          fail_count, pending;
  int          idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both lightly
  int          idle_cycles;

  aes_block_cipher_ecb_cbc_unit dut (.*);

  aes_cipher_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .start_chain_i, .block_high_i,
    .block_low_i, .out_valid_i(out_valid_o), .out_ready_i, .result_high_i(result_high_o),
    .result_low_i(result_low_o), .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    case (idle_mode)
      2:       out_ready_i <= ($urandom_range(99) >= 46);
      3:       out_ready_i <= ($urandom_range(99) >= 7);
      default: out_ready_i <= 1'b1;
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off until every predicted block has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [1:0] klen, input logic [63:0] ivh,
                            input logic [63:0] ivl, input logic mode);
    drain();
    reg_write(RegKey0, k0);
    reg_write(RegKey1, k1);
    reg_write(RegKey2, k2);
    reg_write(RegKey3, k3);
    reg_write(RegKeyLen, {62'd0, klen});
    reg_write(RegIvHigh, ivh);
    reg_write(RegIvLow, ivl);
    reg_write(RegMode, {63'd0, mode});
  endtask

  task automatic send_block(input logic op, input logic start, input logic [63:0] hi,
                            input logic [63:0] lo);
    int pct;
    pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 7 : 0;
    if (pct != 0 && $urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    start_chain_i <= start;
    block_high_i  <= hi;
    block_low_i   <= lo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    int msg_left;
    logic [1:0] klen;
    logic mode;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; op_i = 0; start_chain_i = 0; block_high_i = '0; block_low_i = '0;
    out_ready_i = 1; idle_mode = 0; idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero key, ECB
    send_block(OpEncrypt, 1'b0, '0, '0);
    send_block(OpDecrypt, 1'b1, '1, '1);
    send_block(OpEncrypt, 1'b1, '1, '0);

    // standard 128-bit vector, ECB both ways
    set_config(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, KeyLen128,
               '0, '0, ModeEcb);
    send_block(OpEncrypt, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OpDecrypt, 1'b0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);

    // CBC, 192-bit key: chain as left by reset, then messages with mixed ops
    set_config(rand64(), rand64(), rand64(), '1, KeyLen192, '1, '0, ModeCbc);
    send_block(OpEncrypt, 1'b0, rand64(), rand64());
    send_block(OpEncrypt, 1'b1, '0, '0);
    send_block(OpEncrypt, 1'b0, rand64(), rand64());
    send_block(OpDecrypt, 1'b0, rand64(), rand64());
    send_block(OpEncrypt, 1'b0, '1, '1);
    // new IV must not affect the running chain until a start
    drain();
    reg_write(RegIvHigh, rand64());
    reg_write(RegIvLow, rand64());
    send_block(OpDecrypt, 1'b0, rand64(), rand64());
    send_block(OpDecrypt, 1'b1, rand64(), rand64());
    send_block(OpDecrypt, 1'b0, '0, '1);

    // spare key length code acts as 256 bits; then a plain 256-bit key
    set_config('1, '1, '1, '1, KeyLenSpare, '0, '1, ModeCbc);
    send_block(OpEncrypt, 1'b1, rand64(), rand64());
    send_block(OpDecrypt, 1'b0, rand64(), rand64());
    set_config('0, '0, '0, '0, KeyLen256, rand64(), rand64(), ModeEcb);
    send_block(OpEncrypt, 1'b1, '0, '0);
    send_block(OpDecrypt, 1'b0, '1, '1);

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < 12; ph++) begin
      klen = 2'($urandom_range(3));
      mode = (ph % 3 != 0);
      set_config(pick_word(), pick_word(), pick_word(), pick_word(), klen,
                 pick_word(), pick_word(), mode);
      idle_mode = ph % 4;
      msg_left  = 0;
      for (int n = 0; n < 140; n++) begin
        if (n == 70) drain();
        if (mode == ModeCbc && $urandom_range(9) != 0) begin
          // well-formed messages: start marks the first block only
          if (msg_left == 0) begin
            msg_left = $urandom_range(8, 1);
            send_block(1'($urandom_range(1)), 1'b1, rand64(), rand64());
          end else begin
            send_block(1'($urandom_range(1)), 1'b0, rand64(), rand64());
          end
          msg_left--;
        end else begin
          send_block(1'($urandom_range(1)), 1'($urandom_range(1)), rand64(), rand64());
        end
      end
    end

    in_valid_i <= 1'b0;
    idle_mode  <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
